// ----- src/integrate_fire_neuron_update_core_defines.svh -----
// Assertion macros used by the checker file of the neuron update core.
`ifndef INTEGRATE_FIRE_NEURON_UPDATE_CORE_DEFINES_SVH
`define INTEGRATE_FIRE_NEURON_UPDATE_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define IFN_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define IFN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also watches reset itself.
`define IFN_ASSERT_NORST(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ifn_pkg.sv -----
`default_nettype none

package ifn_pkg;

    // Field widths
    localparam int IDX_W      = 8;
    localparam int POT_W      = 24;
    localparam int RAND_W     = 16;
    localparam int GAIN_W     = 20;
    localparam int FRAC_W     = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Datapath widths: products, rounded terms, unclipped sum
    localparam int PROD_W     = 45;
    localparam int TERM_W     = 29;
    localparam int SUM_W      = 31;
    localparam int Q_SHIFT    = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXC_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INH_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERSIST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_CLIP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CLIP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRE_PROB = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRE_THR  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_RED = 3'd7;

    // Register reset values
    localparam logic [GAIN_W-1:0]        RST_GAIN      = 20'd65536;
    localparam logic [FRAC_W-1:0]        RST_PERSIST   = 17'd0;
    localparam logic signed [POT_W-1:0]  POT_MIN       = 24'sh800000;
    localparam logic signed [POT_W-1:0]  POT_MAX       = 24'sh7FFFFF;
    localparam logic [FRAC_W-1:0]        RST_FIRE_PROB = 17'd65536;
    localparam logic [FRAC_W-1:0]        RST_FIRE_THR  = 17'd0;
    localparam logic [FRAC_W-1:0]        RST_SPIKE_RED = 17'd0;

    typedef logic [IDX_W-1:0]        t_index;
    typedef logic signed [POT_W-1:0] t_potential;
    typedef logic [RAND_W-1:0]       t_random;

    // Membrane store read and write requests
    typedef struct packed {
        logic   en;
        t_index index;
    } t_ram_rd;

    typedef struct packed {
        logic       en;
        t_index     index;
        t_potential data;
    } t_ram_wr;

endpackage

`default_nettype wire

// ----- src/ifn_in_if.sv -----
`default_nettype none

interface ifn_in_if;
    import ifn_pkg::*;

    logic       valid;
    logic       ready;
    t_index     neuron_index;
    t_potential excite_drive;
    t_potential inhibit_drive;
    t_random    random_sample;

    modport source (
        output valid, neuron_index, excite_drive, inhibit_drive, random_sample,
        input  ready
    );

    modport sink (
        input  valid, neuron_index, excite_drive, inhibit_drive, random_sample,
        output ready
    );

endinterface

`default_nettype wire

// ----- src/ifn_out_if.sv -----
`default_nettype none

interface ifn_out_if;
    import ifn_pkg::*;

    logic       valid;
    logic       ready;
    logic       spike;
    t_potential potential;

    modport source (
        output valid, spike, potential,
        input  ready
    );

    modport sink (
        input  valid, spike, potential,
        output ready
    );

endinterface

`default_nettype wire

// ----- src/integrate_fire_neuron_update_core.sv -----
// An accepted word passes stages A, B and C and then lands in the output register.
// Throughput: one word per cycle for distinct neurons while the result side does not stall; a word
// for a neuron still in the read, multiply/sum or fire stage is held until that update is
// written back.
// Reset (synchronous, active low) empties the pipeline, restores the registers and makes every
// membrane potential read as zero at once; ready stays low during reset, then words are taken.
`default_nettype none

module integrate_fire_neuron_update_core #(
    parameter int NEURON_COUNT = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ifn_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ifn_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    ifn_in_if.sink                            i_in,
    ifn_out_if.source                         o_out
);
    import ifn_pkg::*;

    localparam int IDX_SPAN = 1 << IDX_W;
    localparam int DEPTH    = (NEURON_COUNT < IDX_SPAN) ? NEURON_COUNT : IDX_SPAN;
    localparam int CNT_W    = $clog2(NEURON_COUNT + 1) > IDX_W + 1 ?
                              $clog2(NEURON_COUNT + 1) : IDX_W + 1;

    // Round a Q16 product to nearest, ties upward
    function automatic logic signed [TERM_W-1:0] round_q16(
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [PROD_W:0] biased;
        biased = (PROD_W+1)'(prod) + (PROD_W+1)'(signed'(32768));
        return biased[Q_SHIFT+TERM_W-1:Q_SHIFT];
    endfunction

    // Configuration registers
    logic [GAIN_W-1:0]  r_exc_gain;
    logic [GAIN_W-1:0]  r_inh_gain;
    logic [FRAC_W-1:0]  r_persist;
    t_potential         r_low_clip;
    t_potential         r_high_clip;
    logic [FRAC_W-1:0]  r_fire_prob;
    logic [FRAC_W-1:0]  r_fire_thr;
    logic [FRAC_W-1:0]  r_spike_red;

    // Stage A: store read in flight, drives held
    logic               r_a_vld;
    t_index             r_a_idx;
    logic               r_a_inr;
    t_potential         r_a_exc;
    t_potential         r_a_inh;
    t_random            r_a_rnd;

    // Stage B: products
    logic               r_b_vld;
    t_index             r_b_idx;
    logic               r_b_inr;
    t_random            r_b_rnd;
    logic signed [PROD_W-1:0] r_b_pv;
    logic signed [PROD_W-1:0] r_b_pe;
    logic signed [PROD_W-1:0] r_b_pi;

    // Stage C: clipped potential
    logic               r_c_vld;
    t_index             r_c_idx;
    logic               r_c_inr;
    t_random            r_c_rnd;
    t_potential         r_c_pot;

    // Output register
    logic               r_out_vld;
    logic               r_out_spike;
    t_potential         r_out_pot;

    logic               c_adv, c_free, b_adv, b_free, a_adv, a_free;
    logic               in_range, hazard, in_ready, in_acc;
    t_ram_rd            ram_rd;
    t_ram_wr            ram_wr;
    t_potential         ram_data;
    t_potential         v_sel;
    logic signed [PROD_W-1:0] n_pv, n_pe, n_pi;
    logic signed [SUM_W-1:0]  sum, sum_lo, sum_hi;
    logic               fire;
    logic signed [POT_W:0] reduced;
    t_potential         n_pot;

    // Stage flow: each stage moves when the one after it has room
    assign c_adv  = r_c_vld && (!r_out_vld || o_out.ready);
    assign c_free = !r_c_vld || c_adv;
    assign b_adv  = r_b_vld && c_free;
    assign b_free = !r_b_vld || b_adv;
    assign a_adv  = r_a_vld && b_free;
    assign a_free = !r_a_vld || a_adv;

    // Hold a word whose neuron is still being updated further down
    assign in_range = CNT_W'(i_in.neuron_index) < CNT_W'(NEURON_COUNT);
    assign hazard   = in_range && (
                      (r_a_vld && r_a_inr && (r_a_idx == i_in.neuron_index)) ||
                      (r_b_vld && r_b_inr && (r_b_idx == i_in.neuron_index)) ||
                      (r_c_vld && r_c_inr && !c_adv && (r_c_idx == i_in.neuron_index)));
    assign in_ready   = i_rst_n && a_free && !hazard;
    assign in_acc     = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exc_gain  <= RST_GAIN;
            r_inh_gain  <= RST_GAIN;
            r_persist   <= RST_PERSIST;
            r_low_clip  <= POT_MIN;
            r_high_clip <= POT_MAX;
            r_fire_prob <= RST_FIRE_PROB;
            r_fire_thr  <= RST_FIRE_THR;
            r_spike_red <= RST_SPIKE_RED;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_EXC_GAIN:  r_exc_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_INH_GAIN:  r_inh_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_PERSIST:   r_persist   <= i_cfg_data[FRAC_W-1:0];
                CFG_LOW_CLIP:  r_low_clip  <= i_cfg_data[POT_W-1:0];
                CFG_HIGH_CLIP: r_high_clip <= i_cfg_data[POT_W-1:0];
                CFG_FIRE_PROB: r_fire_prob <= i_cfg_data[FRAC_W-1:0];
                CFG_FIRE_THR:  r_fire_thr  <= i_cfg_data[FRAC_W-1:0];
                CFG_SPIKE_RED: r_spike_red <= i_cfg_data[FRAC_W-1:0];
            endcase
        end
    end

    // Membrane store: read on accept, write back as stage C leaves
    assign ram_rd.en    = in_acc;
    assign ram_rd.index = i_in.neuron_index;
    assign ram_wr.en    = c_adv && r_c_inr;
    assign ram_wr.index = r_c_idx;
    assign ram_wr.data  = n_pot;

    ifn_membrane_ram #(
        .DEPTH (DEPTH)
    ) u_ifn_membrane_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (ram_rd),
        .i_wr      (ram_wr),
        .o_rd_data (ram_data)
    );

    // Stage A: multiply potential and drives
    assign v_sel = r_a_inr ? ram_data : '0;
    assign n_pv  = PROD_W'(v_sel) * PROD_W'($signed({1'b0, r_persist}));
    assign n_pe  = PROD_W'(r_a_exc) * PROD_W'($signed({1'b0, r_exc_gain}));
    assign n_pi  = PROD_W'(r_a_inh) * PROD_W'($signed({1'b0, r_inh_gain}));

    // Stage B: sum rounded terms, raise to lower bound, then lower to upper bound
    assign sum    = SUM_W'(round_q16(r_b_pv)) + SUM_W'(round_q16(r_b_pe))
                  - SUM_W'(round_q16(r_b_pi));
    assign sum_lo = (sum < SUM_W'(r_low_clip)) ? SUM_W'(r_low_clip) : sum;
    assign sum_hi = (sum_lo > SUM_W'(r_high_clip)) ? SUM_W'(r_high_clip) : sum_lo;

    // Stage C: fire decision and spike reduction
    assign fire    = ((POT_W+1)'(r_c_pot) >= (POT_W+1)'($signed({1'b0, r_fire_thr}))) &&
                     ({1'b0, r_c_rnd} < r_fire_prob);
    assign reduced = (POT_W+1)'(r_c_pot) - (POT_W+1)'($signed({1'b0, r_spike_red}));
    always_comb begin
        priority if (!fire) begin
            n_pot = r_c_pot;
        end else if (reduced < (POT_W+1)'(POT_MIN)) begin
            n_pot = POT_MIN;
        end else begin
            n_pot = reduced[POT_W-1:0];
        end
    end

    // Stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (a_free) begin
                r_a_vld <= in_acc;
            end
            if (b_free) begin
                r_b_vld <= a_adv;
            end
            if (c_free) begin
                r_c_vld <= b_adv;
            end
            if (!r_out_vld || o_out.ready) begin
                r_out_vld <= c_adv;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_idx <= i_in.neuron_index;
            r_a_inr <= in_range;
            r_a_exc <= i_in.excite_drive;
            r_a_inh <= i_in.inhibit_drive;
            r_a_rnd <= i_in.random_sample;
        end
        if (a_adv) begin
            r_b_idx <= r_a_idx;
            r_b_inr <= r_a_inr;
            r_b_rnd <= r_a_rnd;
            r_b_pv  <= n_pv;
            r_b_pe  <= n_pe;
            r_b_pi  <= n_pi;
        end
        if (b_adv) begin
            r_c_idx <= r_b_idx;
            r_c_inr <= r_b_inr;
            r_c_rnd <= r_b_rnd;
            r_c_pot <= sum_hi[POT_W-1:0];
        end
        if (c_adv) begin
            r_out_spike <= fire;
            r_out_pot   <= n_pot;
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.spike     = r_out_spike;
    assign o_out.potential = r_out_pot;

endmodule

`default_nettype wire

// ----- src/ifn_membrane_ram.sv -----
`default_nettype none

// Membrane potential store: one write and one registered read per cycle.
// Entries read as zero until first written; a write and a read of the same
// entry at the same edge return the written word.
module ifn_membrane_ram #(
    parameter int DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ifn_pkg::t_ram_rd    i_rd,
    input  ifn_pkg::t_ram_wr    i_wr,
    output ifn_pkg::t_potential o_rd_data
);
    import ifn_pkg::*;

    // DEPTH never exceeds the reach of the 8-bit neuron index
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              byp_hit;

    t_potential        r_mem [DEPTH];
    logic [DEPTH-1:0]  r_live;
    t_potential        r_rd_raw;
    logic              r_rd_live;
    logic              r_byp_hit;
    t_potential        r_byp_data;

    assign rd_addr = i_rd.index[ADDR_W-1:0];
    assign wr_addr = i_wr.index[ADDR_W-1:0];
    assign byp_hit = i_wr.en && (i_wr.index == i_rd.index);

    // Storage array
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[wr_addr] <= i_wr.data;
        end
    end

    // Registered read plus same-edge write capture
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_raw   <= r_mem[rd_addr];
            r_rd_live  <= r_live[rd_addr];
            r_byp_hit  <= byp_hit;
            r_byp_data <= i_wr.data;
        end
    end

    // Mark entries written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
        end else if (i_wr.en) begin
            r_live[wr_addr] <= 1'b1;
        end
    end

    // Pick the captured write, the stored word, or zero
    always_comb begin
        priority if (r_byp_hit) begin
            o_rd_data = r_byp_data;
        end else if (r_rd_live) begin
            o_rd_data = r_rd_raw;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

`default_nettype wire

// ----- src/ifn_checker.sv -----
`default_nettype none
`include "integrate_fire_neuron_update_core_defines.svh"

module ifn_checker #(
    parameter int NEURON_COUNT = 256
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic [ifn_pkg::IDX_W-1:0]  i_in_index,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic                       i_out_spike,
    input logic [ifn_pkg::POT_W-1:0]  i_out_potential
);
    import ifn_pkg::*;

    localparam int CNT_W = $clog2(NEURON_COUNT + 1) > IDX_W + 1 ?
                           $clog2(NEURON_COUNT + 1) : IDX_W + 1;

    logic in_acc;
    logic in_range;

    assign in_acc   = i_in_valid && i_in_ready;
    assign in_range = CNT_W'(i_in_index) < CNT_W'(NEURON_COUNT);

    // A stalled result word holds
    `IFN_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_spike) && $stable(i_out_potential), "stalled result word changed")

    // Reset empties the output register
    `IFN_ASSERT_NORST(a_rst_empty, i_clk, !i_rst_n, !i_out_valid, "result word valid after reset")

    // The same neuron cannot enter on two adjacent cycles
    `IFN_ASSERT_NEXT(a_same_neuron, i_clk, i_rst_n, in_acc && in_range, !(in_acc && (i_in_index == $past(i_in_index))), "same neuron accepted back to back")

    // No result can appear sooner than the pipeline depth after reset
    `IFN_ASSERT_IMPL(a_min_latency, i_clk, i_rst_n, $rose(i_rst_n), !i_out_valid ##1 !i_out_valid ##1 !i_out_valid, "result word too early after reset")

endmodule

bind integrate_fire_neuron_update_core ifn_checker #(
    .NEURON_COUNT (NEURON_COUNT)
) u_ifn_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_in_index      (i_in.neuron_index),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_spike     (o_out.spike),
    .i_out_potential (o_out.potential)
);

`default_nettype wire
